/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clock, off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge
`define ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// condition in one cycle implies consequence in the next
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/sgr_pkg.sv */
// ----------------------------------------------------------------------------
// sgr_pkg
// constants, font table and character lookup for the glyph rasterizer
// ----------------------------------------------------------------------------
package sgr_pkg;

   localparam int GLYPH_COLUMNS  = 5;
   localparam int GLYPH_ROWS     = 8;
   localparam int FONT_COLS_MAX  = 8;
   localparam int GLYPH_COUNT    = 33;
   localparam int GLYPH_BITS     = 6;
   localparam int COL_BITS       = 3;
   localparam int ROW_BITS       = 3;
   localparam int FONT_DEPTH     = GLYPH_COUNT * FONT_COLS_MAX;
   localparam int FONT_ADDR_BITS = $clog2(FONT_DEPTH);
   localparam int LINE_BITS      = 8;

   localparam int COORD_BITS     = 10;
   localparam int POS_BITS       = 11;
   localparam int CODE_BITS      = 8;
   localparam int COLOR_BITS     = 16;
   localparam int SCALE_BITS     = 4;
   localparam int CSR_INDEX_BITS = 1;

   localparam logic [COORD_BITS-1:0] SCREEN_WIDTH_RESET  = 10'd240;
   localparam logic [COORD_BITS-1:0] SCREEN_HEIGHT_RESET = 10'd320;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_SCREEN_WIDTH  = 1'b0,
      REG_SCREEN_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic                  known;
      logic [GLYPH_BITS-1:0] glyph;
   } glyph_lookup_type;

   localparam logic [LINE_BITS-1:0] FONT_ROM [GLYPH_COUNT][FONT_COLS_MAX] = '{
      '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E, 8'h00, 8'h00, 8'h00},
      '{8'h00, 8'h42, 8'h7F, 8'h40, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h42, 8'h61, 8'h51, 8'h49, 8'h46, 8'h00, 8'h00, 8'h00},
      '{8'h21, 8'h41, 8'h45, 8'h4B, 8'h31, 8'h00, 8'h00, 8'h00},
      '{8'h18, 8'h14, 8'h12, 8'h7F, 8'h10, 8'h00, 8'h00, 8'h00},
      '{8'h27, 8'h45, 8'h45, 8'h45, 8'h39, 8'h00, 8'h00, 8'h00},
      '{8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30, 8'h00, 8'h00, 8'h00},
      '{8'h01, 8'h71, 8'h09, 8'h05, 8'h03, 8'h00, 8'h00, 8'h00},
      '{8'h36, 8'h49, 8'h49, 8'h49, 8'h36, 8'h00, 8'h00, 8'h00},
      '{8'h06, 8'h49, 8'h49, 8'h29, 8'h1E, 8'h00, 8'h00, 8'h00},
      '{8'h00, 8'h36, 8'h36, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h7C, 8'h12, 8'h11, 8'h12, 8'h7C, 8'h00, 8'h00, 8'h00},
      '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h36, 8'h00, 8'h00, 8'h00},
      '{8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C, 8'h00, 8'h00, 8'h00},
      '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h41, 8'h00, 8'h00, 8'h00},
      '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h01, 8'h00, 8'h00, 8'h00},
      '{8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A, 8'h00, 8'h00, 8'h00},
      '{8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F, 8'h00, 8'h00, 8'h00},
      '{8'h00, 8'h41, 8'h7F, 8'h41, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h7F, 8'h40, 8'h40, 8'h40, 8'h40, 8'h00, 8'h00, 8'h00},
      '{8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F, 8'h00, 8'h00, 8'h00},
      '{8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F, 8'h00, 8'h00, 8'h00},
      '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E, 8'h00, 8'h00, 8'h00},
      '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h06, 8'h00, 8'h00, 8'h00},
      '{8'h7F, 8'h09, 8'h19, 8'h29, 8'h46, 8'h00, 8'h00, 8'h00},
      '{8'h46, 8'h49, 8'h49, 8'h49, 8'h31, 8'h00, 8'h00, 8'h00},
      '{8'h01, 8'h01, 8'h7F, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00},
      '{8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F, 8'h00, 8'h00, 8'h00},
      '{8'h03, 8'h04, 8'h78, 8'h04, 8'h03, 8'h00, 8'h00, 8'h00},
      '{8'h00, 8'h41, 8'h36, 8'h08, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h00, 8'h00, 8'h7F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h63, 8'h14, 8'h08, 8'h14, 8'h63, 8'h00, 8'h00, 8'h00}
   };

   function automatic glyph_lookup_type glyph_lookup(input logic [CODE_BITS-1:0] code);
      glyph_lookup_type res;
      logic [CODE_BITS-1:0] digit;
      res.known = 1'b1;
      res.glyph = '0;
      digit = code - 8'h2F;
      case (code) inside
         8'h20:          res.glyph = 6'd0;
         [8'h30:8'h39]:  res.glyph = digit[GLYPH_BITS-1:0];
         8'h3A:          res.glyph = 6'd11;
         8'h41:          res.glyph = 6'd12;
         8'h43:          res.glyph = 6'd13;
         8'h44:          res.glyph = 6'd14;
         8'h45:          res.glyph = 6'd15;
         8'h46:          res.glyph = 6'd16;
         8'h47:          res.glyph = 6'd17;
         8'h48:          res.glyph = 6'd18;
         8'h49:          res.glyph = 6'd19;
         8'h4C:          res.glyph = 6'd20;
         8'h4D:          res.glyph = 6'd21;
         8'h4E:          res.glyph = 6'd22;
         8'h4F:          res.glyph = 6'd23;
         8'h50:          res.glyph = 6'd24;
         8'h52:          res.glyph = 6'd25;
         8'h53:          res.glyph = 6'd26;
         8'h54:          res.glyph = 6'd27;
         8'h56:          res.glyph = 6'd28;
         8'h59:          res.glyph = 6'd29;
         8'h2F:          res.glyph = 6'd30;
         8'h6C:          res.glyph = 6'd31;
         8'h78:          res.glyph = 6'd32;
         default:        res.known = 1'b0;
      endcase
      return res;
   endfunction

endpackage

/* hw/rtl/scaled_glyph_rasterizer.sv */
// ----------------------------------------------------------------------------
// scaled_glyph_rasterizer
// draws one font character as a list of clipped, scaled filled squares
// ----------------------------------------------------------------------------
// flow: a character passes through a fetch state, the 5 x 8 dot scan of the font ram
//   and a flush state; a new character is taken only while idle; unknown codes and
//   scale zero are dropped without leaving idle
// reset: font ram is loaded from the package table with busy high
// results cannot be stalled; squares leave one per cycle at most
// ----------------------------------------------------------------------------
module scaled_glyph_rasterizer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [sgr_pkg::COORD_BITS-1:0]      req_x_origin,
   input  logic [sgr_pkg::COORD_BITS-1:0]      req_y_origin,
   input  logic [sgr_pkg::CODE_BITS-1:0]       req_char_code,
   input  logic [sgr_pkg::COLOR_BITS-1:0]      req_pen_color,
   input  logic [sgr_pkg::SCALE_BITS-1:0]      req_scale,
   output logic                                rsp_valid,
   output logic [sgr_pkg::COORD_BITS-1:0]      rsp_rect_x,
   output logic [sgr_pkg::COORD_BITS-1:0]      rsp_rect_y,
   output logic [sgr_pkg::SCALE_BITS-1:0]      rsp_rect_width,
   output logic [sgr_pkg::SCALE_BITS-1:0]      rsp_rect_height,
   output logic [sgr_pkg::COLOR_BITS-1:0]      rsp_fill_color,
   output logic                                rsp_last_of_char,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sgr_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [sgr_pkg::COORD_BITS-1:0]      csr_wdata
);

   import sgr_pkg::*;

`include "assert_macros.svh"

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_IDLE,
      ST_FETCH,
      ST_SCAN,
      ST_FLUSH
   } state_type;

   state_type                 state_ff;
   logic [FONT_ADDR_BITS-1:0] load_addr_ff;

   logic [COORD_BITS-1:0]     screen_width_ff;
   logic [COORD_BITS-1:0]     screen_height_ff;

   logic [GLYPH_BITS-1:0]     glyph_ff;
   logic [COORD_BITS-1:0]     y_origin_ff;
   logic [COLOR_BITS-1:0]     color_ff;
   logic [SCALE_BITS-1:0]     scale_ff;
   logic [COL_BITS-1:0]       col_ff;
   logic [ROW_BITS-1:0]       row_ff;
   logic [POS_BITS-1:0]       pos_x_ff;
   logic [POS_BITS-1:0]       pos_y_ff;

   logic                      pend_valid_ff;
   logic [COORD_BITS-1:0]     pend_x_ff;
   logic [COORD_BITS-1:0]     pend_y_ff;
   logic [SCALE_BITS-1:0]     pend_w_ff;
   logic [SCALE_BITS-1:0]     pend_h_ff;

   logic                      rsp_valid_ff;
   logic [COORD_BITS-1:0]     rsp_rect_x_ff;
   logic [COORD_BITS-1:0]     rsp_rect_y_ff;
   logic [SCALE_BITS-1:0]     rsp_rect_width_ff;
   logic [SCALE_BITS-1:0]     rsp_rect_height_ff;
   logic [COLOR_BITS-1:0]     rsp_fill_color_ff;
   logic                      rsp_last_of_char_ff;

   glyph_lookup_type          lookup;
   logic                      accept;
   logic                      load_wr_en;
   logic [LINE_BITS-1:0]      load_data_in;
   logic [FONT_ADDR_BITS-1:0] rd_addr;
   logic [LINE_BITS-1:0]      rd_line;
   logic [COL_BITS-1:0]       col_read_in;
   logic                      row_last;
   logic                      col_last;
   logic                      dot;
   logic                      on_screen;
   logic [POS_BITS-1:0]       room_x;
   logic [POS_BITS-1:0]       room_y;
   logic [SCALE_BITS-1:0]     clip_w_in;
   logic [SCALE_BITS-1:0]     clip_h_in;
   logic [POS_BITS-1:0]       scale_ext;

   // font table load port
   assign load_wr_en   = (state_ff == ST_LOAD);
   assign load_data_in = FONT_ROM[load_addr_ff[FONT_ADDR_BITS-1:COL_BITS]]
                                 [load_addr_ff[COL_BITS-1:0]];

   assign row_last    = (row_ff == ROW_BITS'(GLYPH_ROWS - 1));
   assign col_last    = (col_ff == COL_BITS'(GLYPH_COLUMNS - 1));
   assign col_read_in = (state_ff == ST_SCAN && row_last) ? col_ff + 1'b1 : col_ff;
   assign rd_addr     = FONT_ADDR_BITS'({glyph_ff, col_read_in});

   sgr_ram #(
      .WIDTH (LINE_BITS),
      .DEPTH (FONT_DEPTH)
   ) u_font_ram (
      .clock   (clock),
      .wr_en   (load_wr_en),
      .wr_addr (load_addr_ff),
      .wr_data (load_data_in),
      .rd_addr (rd_addr),
      .rd_data (rd_line)
   );

   assign lookup    = glyph_lookup(req_char_code);
   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   // clipping of the square at the current dot
   assign scale_ext = POS_BITS'(scale_ff);
   assign dot       = rd_line[row_ff];
   assign on_screen = (pos_x_ff < POS_BITS'(screen_width_ff)) &&
                      (pos_y_ff < POS_BITS'(screen_height_ff));
   assign room_x    = POS_BITS'(screen_width_ff) - pos_x_ff;
   assign room_y    = POS_BITS'(screen_height_ff) - pos_y_ff;
   assign clip_w_in = (room_x > scale_ext) ? scale_ff : room_x[SCALE_BITS-1:0];
   assign clip_h_in = (room_y > scale_ext) ? scale_ff : room_y[SCALE_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff  <= SCREEN_WIDTH_RESET;
         screen_height_ff <= SCREEN_HEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            REG_SCREEN_WIDTH:  screen_width_ff  <= csr_wdata;
            REG_SCREEN_HEIGHT: screen_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         load_addr_ff  <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         col_ff        <= '0;
         row_ff        <= '0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_LOAD: begin
               load_addr_ff <= load_addr_ff + 1'b1;
               if (load_addr_ff == FONT_ADDR_BITS'(FONT_DEPTH - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  glyph_ff      <= lookup.glyph;
                  y_origin_ff   <= req_y_origin;
                  color_ff      <= req_pen_color;
                  scale_ff      <= req_scale;
                  pos_x_ff      <= POS_BITS'(req_x_origin);
                  pos_y_ff      <= POS_BITS'(req_y_origin);
                  col_ff        <= '0;
                  row_ff        <= '0;
                  pend_valid_ff <= 1'b0;
                  if (lookup.known && req_scale != '0) begin
                     state_ff <= ST_FETCH;
                  end
               end
            end
            ST_FETCH: begin
               state_ff <= ST_SCAN;
            end
            ST_SCAN: begin
               // hold one square back so the final one can be flagged
               if (dot && on_screen) begin
                  if (pend_valid_ff) begin
                     rsp_valid_ff        <= 1'b1;
                     rsp_rect_x_ff       <= pend_x_ff;
                     rsp_rect_y_ff       <= pend_y_ff;
                     rsp_rect_width_ff   <= pend_w_ff;
                     rsp_rect_height_ff  <= pend_h_ff;
                     rsp_fill_color_ff   <= color_ff;
                     rsp_last_of_char_ff <= 1'b0;
                  end
                  pend_valid_ff <= 1'b1;
                  pend_x_ff     <= pos_x_ff[COORD_BITS-1:0];
                  pend_y_ff     <= pos_y_ff[COORD_BITS-1:0];
                  pend_w_ff     <= clip_w_in;
                  pend_h_ff     <= clip_h_in;
               end
               if (row_last) begin
                  row_ff   <= '0;
                  col_ff   <= col_ff + 1'b1;
                  pos_x_ff <= pos_x_ff + scale_ext;
                  pos_y_ff <= POS_BITS'(y_origin_ff);
                  if (col_last) begin
                     state_ff <= ST_FLUSH;
                  end
               end else begin
                  row_ff   <= row_ff + 1'b1;
                  pos_y_ff <= pos_y_ff + scale_ext;
               end
            end
            ST_FLUSH: begin
               if (pend_valid_ff) begin
                  rsp_valid_ff        <= 1'b1;
                  rsp_rect_x_ff       <= pend_x_ff;
                  rsp_rect_y_ff       <= pend_y_ff;
                  rsp_rect_width_ff   <= pend_w_ff;
                  rsp_rect_height_ff  <= pend_h_ff;
                  rsp_fill_color_ff   <= color_ff;
                  rsp_last_of_char_ff <= 1'b1;
               end
               pend_valid_ff <= 1'b0;
               state_ff      <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_rect_x       = rsp_rect_x_ff;
   assign rsp_rect_y       = rsp_rect_y_ff;
   assign rsp_rect_width   = rsp_rect_width_ff;
   assign rsp_rect_height  = rsp_rect_height_ff;
   assign rsp_fill_color   = rsp_fill_color_ff;
   assign rsp_last_of_char = rsp_last_of_char_ff;

   `ASSERT_ALWAYS(a_rect_nonzero, !rsp_valid || (rsp_rect_width != '0 && rsp_rect_height != '0), "empty square emitted")
   `ASSERT_ALWAYS(a_rsp_after_busy, !rsp_valid || $past(busy), "square emitted while idle")
   `ASSERT_NEXT(a_last_ends_char, rsp_valid && rsp_last_of_char, !rsp_valid, "square after last of char")
   `ASSERT_NEXT(a_pend_cleared, state_ff == ST_FLUSH, !pend_valid_ff && state_ff == ST_IDLE, "held square left after flush")

endmodule

/* hw/rtl/sgr_ram.sv */
// ----------------------------------------------------------------------------
// sgr_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module sgr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
